FILE: src/tibf_pkg.sv
// Shared types, codes and lookup helpers for the two-index Bloom filter.
package tibf_pkg;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int IDX_W  = 16;
    localparam int FB_W   = 9;
    localparam int BITS_W = 12;
    localparam int CNT_W  = 12;

    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT  = 2'd2;

    localparam logic [1:0] ADDR_FILTER_BYTES = 2'd0;

    localparam logic [FB_W-1:0] FB_RESET = 9'd256;

    localparam logic [2:0] CLEAR_IN_NIBBLE [16] = '{
        3'd4, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1,
        3'd3, 3'd2, 3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd0
    };

    // number of clear bits in one store byte
    function automatic logic [3:0] clear_in_byte(input logic [7:0] b);
        logic [3:0] lo;
        logic [3:0] hi;
        lo = {1'b0, CLEAR_IN_NIBBLE[b[3:0]]};
        hi = {1'b0, CLEAR_IN_NIBBLE[b[7:4]]};
        return lo + hi;
    endfunction

endpackage

FILE: src/tibf_mod.sv
// Restoring remainder unit: one dividend bit per cycle, shared by both indices.
module tibf_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tibf_pkg::IDX_W-1:0]    i_dividend,
    input  logic [tibf_pkg::BITS_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [tibf_pkg::BITS_W-1:0]   o_rem
);

    localparam int STEP_W = $clog2(tibf_pkg::IDX_W);

    logic [tibf_pkg::IDX_W-1:0]  r_dvd;
    logic [tibf_pkg::BITS_W-1:0] r_rem;
    logic [STEP_W-1:0]           r_step;
    logic                        r_busy;
    logic                        r_done;

    logic [tibf_pkg::BITS_W:0]   trial;
    logic [tibf_pkg::BITS_W:0]   diff;
    logic [tibf_pkg::BITS_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[tibf_pkg::IDX_W-1]};
        diff  = trial - {1'b0, i_divisor};
        // partial remainder stays below the divisor, so it fits back in BITS_W
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = diff[tibf_pkg::BITS_W-1:0];
        end else begin
            n_rem = trial[tibf_pkg::BITS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_dvd  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_dvd  <= {r_dvd[tibf_pkg::IDX_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(tibf_pkg::IDX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: src/two_index_bloom_filter.sv
// Two-index Bloom filter: top level with sequencer, bit store and register port.
//
// Input channel (i_valid/o_ready) takes one request: i_operation and i_key.
// Operation 0 queries the key, 1 inserts it, 2 counts clear bits in the bytes
// in use, 3 does nothing. Each request yields exactly one result on the output
// channel (o_valid/i_ready): o_found for a query, o_zero_count for a count.
// Each 16-bit half of the key is reduced modulo the filter bit count
// (8 * filter_bytes) by one shared remainder unit, one bit per cycle.
// Query or insert: two passes through the remainder unit (MOD1, MOD2), three
// store steps (RD1, RD2, RD3) and the load of the output register in DONE.
// Count: one store byte read per cycle over the bytes in use, then DONE.
// Operation 3 goes straight to DONE.
// One request is in flight at a time; o_ready is high only while idle, so
// a new request is taken only once the last one has left DONE.
// A finished result waits in an output register, so the next request is
// accepted while the receiver stalls; a second result then waits for it.
// After reset the store is cleared by a pass over all MAX_BYTES bytes, during
// which o_ready is low; register writes are taken throughout.
// filter_bytes (APB address 0) resets to 256; 0 acts as 1, values above
// MAX_BYTES act as MAX_BYTES. Changing it does not clear the store.
module two_index_bloom_filter #(
    parameter int MAX_BYTES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tibf_pkg::OP_W-1:0]       i_operation,
    input  logic [tibf_pkg::KEY_W-1:0]      i_key,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_found,
    output logic [tibf_pkg::CNT_W-1:0]      o_zero_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [1:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_MOD1  = 9'b000000100,
        S_MOD2  = 9'b000001000,
        S_RD1   = 9'b000010000,
        S_RD2   = 9'b000100000,
        S_RD3   = 9'b001000000,
        S_CNT   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state                          r_state;
    logic [tibf_pkg::FB_W-1:0]       r_fb;
    logic [tibf_pkg::OP_W-1:0]       r_op;
    logic [tibf_pkg::KEY_W-1:0]      r_key;
    logic [tibf_pkg::BITS_W-1:0]     r_idx1;
    logic [tibf_pkg::BITS_W-1:0]     r_idx2;
    logic                            r_bit1;
    logic [tibf_pkg::FB_W-1:0]       r_ptr;
    logic                            r_pend;
    logic [tibf_pkg::CNT_W-1:0]      r_acc;
    logic [AW-1:0]                   r_clr;
    logic                            r_res_found;
    logic [tibf_pkg::CNT_W-1:0]      r_res_zero;
    logic                            r_out_valid;
    logic                            r_found;
    logic [tibf_pkg::CNT_W-1:0]      r_zero;
    logic [7:0]                      r_mem [MAX_BYTES];
    logic [7:0]                      r_rd_data;

    logic [tibf_pkg::FB_W-1:0]       nbytes;
    logic [tibf_pkg::BITS_W-1:0]     nbits;
    logic                            accept;
    logic                            out_free;
    logic                            mod_start;
    logic [tibf_pkg::IDX_W-1:0]      mod_dividend;
    logic                            mod_done;
    logic [tibf_pkg::BITS_W-1:0]     mod_rem;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [7:0]                      mem_wdata;
    logic [AW-1:0]                   mem_raddr;
    logic [7:0]                      mask1;
    logic [7:0]                      mask2;
    logic                            same_byte;
    logic                            bit2;

    // clamp the register to the usable byte range
    always_comb begin
        if (r_fb == '0) begin
            nbytes = tibf_pkg::FB_W'(1);
        end else if (int'(r_fb) > MAX_BYTES) begin
            nbytes = tibf_pkg::FB_W'(MAX_BYTES);
        end else begin
            nbytes = r_fb;
        end
        nbits = {nbytes, 3'b000};
    end

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign mask1     = 8'(1) << r_idx1[2:0];
    assign mask2     = 8'(1) << r_idx2[2:0];
    assign same_byte = (r_idx1[tibf_pkg::BITS_W-1:3] == r_idx2[tibf_pkg::BITS_W-1:3]);
    assign bit2      = r_rd_data[r_idx2[2:0]];

    assign mod_start    = (accept && (i_operation == tibf_pkg::OP_QUERY ||
                                      i_operation == tibf_pkg::OP_INSERT))
                        || (r_state == S_MOD1 && mod_done);
    assign mod_dividend = (r_state == S_IDLE) ? i_key[tibf_pkg::IDX_W-1:0]
                                              : r_key[tibf_pkg::KEY_W-1:tibf_pkg::IDX_W];

    tibf_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (nbits),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // store port select
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        mem_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_RD1: begin
                mem_raddr = AW'(r_idx1[tibf_pkg::BITS_W-1:3]);
            end
            S_RD2: begin
                mem_raddr = AW'(r_idx2[tibf_pkg::BITS_W-1:3]);
                mem_we    = (r_op == tibf_pkg::OP_INSERT);
                mem_waddr = AW'(r_idx1[tibf_pkg::BITS_W-1:3]);
                mem_wdata = r_rd_data | mask1;
            end
            S_RD3: begin
                // the read in RD2 missed the first write when both bits share a byte
                mem_we    = (r_op == tibf_pkg::OP_INSERT);
                mem_waddr = AW'(r_idx2[tibf_pkg::BITS_W-1:3]);
                mem_wdata = r_rd_data | mask2 | (same_byte ? mask1 : 8'h00);
            end
            S_CNT: begin
                mem_raddr = AW'(r_ptr);
            end
            S_IDLE, S_MOD1, S_MOD2, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr == tibf_pkg::ADDR_FILTER_BYTES)
                  ? {{(32 - tibf_pkg::FB_W){1'b0}}, r_fb} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb <= tibf_pkg::FB_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_fb <= pwdata[tibf_pkg::FB_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a result loaded in DONE takes over the output register instead
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MAX_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op        <= i_operation;
                        r_key       <= i_key;
                        r_res_found <= 1'b0;
                        r_res_zero  <= '0;
                        r_ptr       <= '0;
                        r_acc       <= '0;
                        r_pend      <= 1'b0;
                        if (i_operation == tibf_pkg::OP_QUERY ||
                            i_operation == tibf_pkg::OP_INSERT) begin
                            r_state <= S_MOD1;
                        end else if (i_operation == tibf_pkg::OP_COUNT) begin
                            r_state <= S_CNT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MOD1: begin
                    if (mod_done) begin
                        r_idx1  <= mod_rem;
                        r_state <= S_MOD2;
                    end
                end
                S_MOD2: begin
                    if (mod_done) begin
                        r_idx2  <= mod_rem;
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_bit1  <= r_rd_data[r_idx1[2:0]];
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_res_found <= (r_op == tibf_pkg::OP_QUERY) && r_bit1 && bit2;
                    r_state     <= S_DONE;
                end
                S_CNT: begin
                    // issue one byte read a cycle, add the previous byte's clear bits
                    if (r_ptr < nbytes) begin
                        r_ptr  <= r_ptr + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_acc <= r_acc
                               + tibf_pkg::CNT_W'(tibf_pkg::clear_in_byte(r_rd_data));
                    end
                    if (r_ptr == nbytes && !r_pend) begin
                        r_res_zero <= r_acc;
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_found     <= r_res_found;
                        r_zero      <= r_res_zero;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_found;
    assign o_zero_count = r_zero;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for the two-index Bloom filter: directed and random requests vs. a predictor.
module tb;

    localparam int LIMIT       = 1_000_000;
    localparam int STORE_BYTES = 256;
    localparam logic [tibf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Predicts found/zero_count per request and checks results in order.
    class bloom_tracker;
        logic [7:0]                 store [STORE_BYTES];
        logic [tibf_pkg::FB_W-1:0]  fb_reg;
        logic                       found_q [$];
        logic [tibf_pkg::CNT_W-1:0] zeros_q [$];
        int                         n_errors;
        int                         n_checked;
        int                         n_counts;

        function new();
            foreach (store[i]) store[i] = 8'h00;
            fb_reg    = tibf_pkg::FB_RESET;
            n_errors  = 0;
            n_checked = 0;
            n_counts  = 0;
        endfunction

        function void note_request(logic [tibf_pkg::OP_W-1:0] op,
                                   logic [tibf_pkg::KEY_W-1:0] key);
            int unsigned                live;
            int unsigned                nbits;
            int unsigned                idx1;
            int unsigned                idx2;
            int unsigned                zeros;
            logic                       f;
            logic [tibf_pkg::CNT_W-1:0] z;
            live  = (fb_reg == 0) ? 1 : (fb_reg > STORE_BYTES) ? STORE_BYTES : fb_reg;
            nbits = live * 8;
            idx1  = key[15:0] % nbits;
            idx2  = key[31:16] % nbits;
            f     = 1'b0;
            zeros = 0;
            case (op)
                tibf_pkg::OP_QUERY: begin
                    f = store[idx1 / 8][idx1 % 8] && store[idx2 / 8][idx2 % 8];
                end
                tibf_pkg::OP_INSERT: begin
                    store[idx1 / 8][idx1 % 8] = 1'b1;
                    store[idx2 / 8][idx2 % 8] = 1'b1;
                end
                tibf_pkg::OP_COUNT: begin
                    for (int i = 0; i < live; i++) zeros += 8 - $countones(store[i]);
                    n_counts++;
                end
                default: ;
            endcase
            z = tibf_pkg::CNT_W'(zeros);
            found_q.push_back(f);
            zeros_q.push_back(z);
        endfunction

        function void check_result(logic found, logic [tibf_pkg::CNT_W-1:0] zeros);
            logic                       f_exp;
            logic [tibf_pkg::CNT_W-1:0] z_exp;
            if (found_q.size() == 0) begin
                n_errors++;
                $display("%0t: result with no request pending: found %0b zero_count %0d",
                         $time, found, zeros);
                return;
            end
            f_exp = found_q.pop_front();
            z_exp = zeros_q.pop_front();
            n_checked++;
            if (found !== f_exp) begin
                n_errors++;
                $display("%0t: found mismatch: expected %0b actual %0b", $time, f_exp, found);
            end
            if (zeros !== z_exp) begin
                n_errors++;
                $display("%0t: zero_count mismatch: expected %0d actual %0d",
                         $time, z_exp, zeros);
            end
        endfunction
    endclass

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_valid     = 1'b0;
    logic [tibf_pkg::OP_W-1:0]   i_operation = tibf_pkg::OP_QUERY;
    logic [tibf_pkg::KEY_W-1:0]  i_key       = '0;
    logic                        i_ready     = 1'b0;
    logic                        psel        = 1'b0;
    logic                        penable     = 1'b0;
    logic                        pwrite      = 1'b0;
    logic [1:0]                  paddr       = tibf_pkg::ADDR_FILTER_BYTES;
    logic [31:0]                 pwdata      = '0;
    logic                        o_ready;
    logic                        o_valid;
    logic                        o_found;
    logic [tibf_pkg::CNT_W-1:0]  o_zero_count;
    logic [31:0]                 prdata;
    logic                        pready;

    bloom_tracker                tracker = new();
    logic [tibf_pkg::KEY_W-1:0]  known_keys [$];
    logic                        no_gaps = 1'b0;
    int                          cycles  = 0;
    int                          n_sent  = 0;
    int                          n_sizes = 0;

    two_index_bloom_filter u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_key        (i_key),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_zero_count (o_zero_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     tracker.found_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stall the result side at random
    always @(posedge i_clk) begin
        i_ready <= no_gaps || ($urandom_range(99) >= 26);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) tracker.check_result(o_found, o_zero_count);
    end

    task automatic send_request(input logic [tibf_pkg::OP_W-1:0] op,
                                input logic [tibf_pkg::KEY_W-1:0] key);
        if (!no_gaps) begin
            while ($urandom_range(99) < 26) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_request(op, key);
        n_sent++;
    endtask

    // drop valid and hold until every pending result has come back
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (tracker.found_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_filter_bytes(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tibf_pkg::ADDR_FILTER_BYTES;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tracker.fb_reg = value[tibf_pkg::FB_W-1:0];
        // read the register back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[tibf_pkg::FB_W-1:0] !== value[tibf_pkg::FB_W-1:0]) begin
            tracker.n_errors++;
            $display("%0t: filter_bytes readback mismatch: expected %0d actual %0d",
                     $time, value[tibf_pkg::FB_W-1:0], prdata[tibf_pkg::FB_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        n_sizes++;
    endtask

    // mostly inserts and queries of inserted keys, some fresh queries, rare counts and unused operations
    task automatic run_phase(input int n);
        logic [tibf_pkg::OP_W-1:0]  op;
        logic [tibf_pkg::KEY_W-1:0] key;
        int                         pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            key  = $urandom;
            if (pick < 40) begin
                op = tibf_pkg::OP_INSERT;
                known_keys.push_back(key);
                if (known_keys.size() > 64) void'(known_keys.pop_front());
            end else if (pick < 75 && known_keys.size() > 0) begin
                op  = tibf_pkg::OP_QUERY;
                key = known_keys[$urandom_range(known_keys.size() - 1)];
            end else if (pick < 95) begin
                op = tibf_pkg::OP_QUERY;
            end else if (pick < 98) begin
                op = tibf_pkg::OP_COUNT;
            end else begin
                op = OP_UNUSED;
            end
            send_request(op, key);
        end
    endtask

    initial begin
        int sizes [10];
        sizes    = '{256, 1, 511, 2, 0, 37, 255, 256, 8, 100};
        sizes[9] = $urandom_range(3, 200);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-size store straight out of reset
        send_request(tibf_pkg::OP_COUNT, 32'h0);
        send_request(tibf_pkg::OP_QUERY, 32'h0);
        send_request(tibf_pkg::OP_INSERT, 32'h0);
        send_request(tibf_pkg::OP_QUERY, 32'h0);
        send_request(tibf_pkg::OP_INSERT, 32'hffff_ffff);
        send_request(tibf_pkg::OP_QUERY, 32'hffff_ffff);
        send_request(tibf_pkg::OP_QUERY, 32'h0000_ffff);
        send_request(OP_UNUSED, 32'ha5a5_5a5a);
        send_request(tibf_pkg::OP_COUNT, 32'hffff_ffff);
        send_request(tibf_pkg::OP_INSERT, 32'h1234_5678);
        send_request(tibf_pkg::OP_QUERY, 32'h5678_1234);

        // single byte: indices wrap modulo 8, upper bytes keep their bits
        wait_idle();
        write_filter_bytes(32'd1);
        send_request(tibf_pkg::OP_INSERT, 32'h0005_0003);
        send_request(tibf_pkg::OP_QUERY, 32'h000d_000b);
        send_request(tibf_pkg::OP_COUNT, 32'h0);

        // zero size acts as one byte
        wait_idle();
        write_filter_bytes(32'd0);
        send_request(tibf_pkg::OP_QUERY, 32'hffff_0000);
        send_request(tibf_pkg::OP_COUNT, 32'h0);

        // oversize acts as the full store, earlier bits still there
        wait_idle();
        write_filter_bytes(32'd511);
        send_request(tibf_pkg::OP_COUNT, 32'h0);
        send_request(tibf_pkg::OP_QUERY, 32'h0000_ffff);

        wait_idle();
        write_filter_bytes(32'd2);
        send_request(tibf_pkg::OP_INSERT, 32'hffff_fff0);
        send_request(tibf_pkg::OP_QUERY, 32'h000f_0000);
        send_request(tibf_pkg::OP_COUNT, 32'h0);

        for (int p = 0; p < 10; p++) begin
            wait_idle();
            write_filter_bytes(sizes[p]);
            no_gaps <= (p == 6);
            run_phase(90);
        end

        wait_idle();
        no_gaps <= 1'b0;
        repeat (300) @(posedge i_clk);

        $display("Sent %0d requests (%0d zero counts) across %0d filter sizes from 0 to 511,",
                 n_sent, tracker.n_counts, n_sizes + 1);
        $display("checked %0d results with random stalls on both channels.",
                 tracker.n_checked);
        if (tracker.n_errors == 0 && tracker.found_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived", tracker.n_errors,
                     tracker.found_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
